>>> hw/rtl/bt_module_command_handshake_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the command handshake engine
// both sample on the rising edge of clk and stand still while arst_n is low
// ----------------------------------------------------------------------------
`ifndef BT_MODULE_COMMAND_HANDSHAKE_MACROS_SVH
`define BT_MODULE_COMMAND_HANDSHAKE_MACROS_SVH

// property that must hold at every edge
`define BTMCH_ASSERT(label, prop, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
else $error(msg);

// when pre holds, post must hold in the next cycle
`define BTMCH_ASSERT_NEXT(label, pre, post, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
else $error(msg);

`endif

>>> hw/rtl/btmch_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btmch_pkg
// types, constants and the microcode table of the command handshake engine
// ----------------------------------------------------------------------------
package btmch_pkg;

	localparam int BODY_KEEP       = 8;
	localparam int PIN_BYTES       = 16;
	localparam int BODY_IDX_W      = $clog2(BODY_KEEP);
	localparam int ECHO_BYTES      = 7;
	localparam int PIN_FIELD_BYTES = 16;
	localparam int UPC_W           = 5;
	localparam int LOOP_W          = 4;
	localparam int CFG_ADDR_W      = 6;
	localparam int CFG_DATA_W      = 64;
	localparam int REG_SEL_LSB     = 3;

	typedef enum logic [1:0] {
		MODE_LENGTH = 2'd0,
		MODE_BODY   = 2'd1,
		MODE_BYPASS = 2'd2,
		MODE_HOLD   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		OPC_BYTE  = 2'd0,
		OPC_LINK  = 2'd1,
		OPC_START = 2'd2,
		OPC_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		KIND_TX     = 3'd0,
		KIND_FWD    = 3'd1,
		KIND_ACCEPT = 3'd2,
		KIND_SOFT   = 3'd3,
		KIND_HARD   = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		REG_PIN_HIGH   = 3'd0,
		REG_PIN_LOW    = 3'd1,
		REG_RX_CODES   = 3'd2,
		REG_RX_CONNECT = 3'd3,
		REG_TX_CODES   = 3'd4
	} reg_idx_t;

	// byte source of one microcode step
	typedef enum logic [3:0] {
		SRC_ZERO   = 4'd0,
		SRC_RX     = 4'd1,
		SRC_IMM    = 4'd2,
		SRC_TXCODE = 4'd3,
		SRC_STORE  = 4'd4,
		SRC_PIN    = 4'd5,
		SRC_HANDLE = 4'd6,
		SRC_SUMHI  = 4'd7,
		SRC_SUMLO  = 4'd8
	} src_t;

	// sequencing of one step
	typedef enum logic [1:0] {
		OP_NEXT = 2'd0,
		OP_LOOP = 2'd1,
		OP_END  = 2'd2
	} op_t;

	typedef struct packed {
		src_t              src;
		kind_t             kind;
		logic [7:0]        imm;
		logic [LOOP_W-1:0] cnt;
		logic              acc;
		logic              last;
		op_t               op;
	} ucode_t;

	typedef struct packed {
		logic              busy;
		logic              fire;
		logic [LOOP_W-1:0] idx;
	} seq_stat_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] rx_byte;
	} in_word_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
		logic       last;
	} out_word_t;

	// tx type code slots
	localparam logic [7:0] TX_OPEN_PORT = 8'd0;
	localparam logic [7:0] TX_PIN_CODE  = 8'd1;
	localparam logic [7:0] TX_ACCEPT    = 8'd2;
	localparam logic [7:0] TX_OPEN_STRM = 8'd3;

	// reply length bytes: body plus two checksum bytes
	localparam logic [7:0] LEN_OPEN_PORT = 8'(1 + 2);
	localparam logic [7:0] LEN_PIN       = 8'(1 + ECHO_BYTES + PIN_FIELD_BYTES + 2);
	localparam logic [7:0] LEN_TWO_BYTE  = 8'(2 + 2);
	localparam logic [7:0] ACCEPT_FLAG   = 8'd1;

	localparam logic [LOOP_W-1:0] ECHO_LAST = LOOP_W'(ECHO_BYTES - 1);
	localparam logic [LOOP_W-1:0] PIN_LAST  = LOOP_W'(PIN_FIELD_BYTES - 1);

	// program entry points
	localparam logic [UPC_W-1:0] PC_FWD       = 5'd0;
	localparam logic [UPC_W-1:0] PC_SOFT      = 5'd1;
	localparam logic [UPC_W-1:0] PC_HARD      = 5'd2;
	localparam logic [UPC_W-1:0] PC_RESET_IND = 5'd3;
	localparam logic [UPC_W-1:0] PC_PIN_REQ   = 5'd7;
	localparam logic [UPC_W-1:0] PC_CONN_REQ  = 5'd13;
	localparam logic [UPC_W-1:0] PC_CONN_RES  = 5'd18;

	function automatic ucode_t mc(input src_t s, input kind_t k, input logic [7:0] imm,
		input logic [LOOP_W-1:0] cnt, input logic acc, input logic last, input op_t op);
		ucode_t w;
		w.src  = s;
		w.kind = k;
		w.imm  = imm;
		w.cnt  = cnt;
		w.acc  = acc;
		w.last = last;
		w.op   = op;
		return w;
	endfunction

	function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] pc);
		ucode_t w;
		unique case (pc)
			// single word programs
			5'd0:    w = mc(SRC_RX,     KIND_FWD,    8'd0,          '0,        1'b0, 1'b1, OP_END);
			5'd1:    w = mc(SRC_ZERO,   KIND_SOFT,   8'd0,          '0,        1'b0, 1'b1, OP_END);
			5'd2:    w = mc(SRC_ZERO,   KIND_HARD,   8'd0,          '0,        1'b0, 1'b1, OP_END);
			// open port request
			5'd3:    w = mc(SRC_IMM,    KIND_TX,     LEN_OPEN_PORT, '0,        1'b0, 1'b0, OP_NEXT);
			5'd4:    w = mc(SRC_TXCODE, KIND_TX,     TX_OPEN_PORT,  '0,        1'b1, 1'b0, OP_NEXT);
			5'd5:    w = mc(SRC_SUMHI,  KIND_TX,     8'd0,          '0,        1'b0, 1'b0, OP_NEXT);
			5'd6:    w = mc(SRC_SUMLO,  KIND_TX,     8'd0,          '0,        1'b0, 1'b1, OP_END);
			// pin reply: address echo then pin field
			5'd7:    w = mc(SRC_IMM,    KIND_TX,     LEN_PIN,       '0,        1'b0, 1'b0, OP_NEXT);
			5'd8:    w = mc(SRC_TXCODE, KIND_TX,     TX_PIN_CODE,   '0,        1'b1, 1'b0, OP_NEXT);
			5'd9:    w = mc(SRC_STORE,  KIND_TX,     8'd0,          ECHO_LAST, 1'b1, 1'b0, OP_LOOP);
			5'd10:   w = mc(SRC_PIN,    KIND_TX,     8'd0,          PIN_LAST,  1'b1, 1'b0, OP_LOOP);
			5'd11:   w = mc(SRC_SUMHI,  KIND_TX,     8'd0,          '0,        1'b0, 1'b0, OP_NEXT);
			5'd12:   w = mc(SRC_SUMLO,  KIND_TX,     8'd0,          '0,        1'b0, 1'b1, OP_END);
			// accept connection
			5'd13:   w = mc(SRC_IMM,    KIND_TX,     LEN_TWO_BYTE,  '0,        1'b0, 1'b0, OP_NEXT);
			5'd14:   w = mc(SRC_TXCODE, KIND_TX,     TX_ACCEPT,     '0,        1'b1, 1'b0, OP_NEXT);
			5'd15:   w = mc(SRC_IMM,    KIND_TX,     ACCEPT_FLAG,   '0,        1'b1, 1'b0, OP_NEXT);
			5'd16:   w = mc(SRC_SUMHI,  KIND_TX,     8'd0,          '0,        1'b0, 1'b0, OP_NEXT);
			5'd17:   w = mc(SRC_SUMLO,  KIND_TX,     8'd0,          '0,        1'b0, 1'b1, OP_END);
			// accept strobe then open stream
			5'd18:   w = mc(SRC_ZERO,   KIND_ACCEPT, 8'd0,          '0,        1'b0, 1'b0, OP_NEXT);
			5'd19:   w = mc(SRC_IMM,    KIND_TX,     LEN_TWO_BYTE,  '0,        1'b0, 1'b0, OP_NEXT);
			5'd20:   w = mc(SRC_TXCODE, KIND_TX,     TX_OPEN_STRM,  '0,        1'b1, 1'b0, OP_NEXT);
			5'd21:   w = mc(SRC_HANDLE, KIND_TX,     8'd0,          '0,        1'b1, 1'b0, OP_NEXT);
			5'd22:   w = mc(SRC_SUMHI,  KIND_TX,     8'd0,          '0,        1'b0, 1'b0, OP_NEXT);
			5'd23:   w = mc(SRC_SUMLO,  KIND_TX,     8'd0,          '0,        1'b0, 1'b1, OP_END);
			default: w = mc(SRC_ZERO,   KIND_TX,     8'd0,          '0,        1'b0, 1'b1, OP_END);
		endcase
		return w;
	endfunction

	// pin byte i, first byte in the top bits, zero at or past PIN_BYTES
	function automatic logic [7:0] pin_byte(input logic [63:0] hi, input logic [63:0] lo,
		input logic [LOOP_W-1:0] i);
		logic [63:0] w;
		w = i[3] ? lo : hi;
		w = w >> {~i[2:0], 3'b000};
		if (int'(i) >= PIN_BYTES) begin
			return 8'd0;
		end
		return w[7:0];
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/btmch_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btmch_seq
// microcode sequencer: step counter, loop index and the control store
// ----------------------------------------------------------------------------
module btmch_seq (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [btmch_pkg::UPC_W-1:0] entry,
	input  wire logic                        step_en,
	output btmch_pkg::ucode_t                uword,
	output btmch_pkg::seq_stat_t             stat
);
	import btmch_pkg::*;

	logic              busy_q;
	logic [UPC_W-1:0]  pc_q;
	logic [LOOP_W-1:0] idx_q;
	logic              fire;

	assign uword = ucode_rom(pc_q);
	assign fire  = busy_q && step_en;

	assign stat.busy = busy_q;
	assign stat.fire = fire;
	assign stat.idx  = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			pc_q   <= entry;
			idx_q  <= '0;
		end else if (fire) begin
			unique case (uword.op)
				OP_NEXT: begin
					pc_q  <= pc_q + 1'b1;
					idx_q <= '0;
				end
				OP_LOOP: begin
					// stay on this step until the index reaches the count
					if (idx_q == uword.cnt) begin
						pc_q  <= pc_q + 1'b1;
						idx_q <= '0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
					busy_q <= 1'b0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/bt_module_command_handshake.sv
`timescale 1ns / 1ps
`default_nettype none
// sequencer: starts at the edge that takes an item; each step it fires loads one result
//   word into the output register, one word per cycle while out_ready is high
// input: items without results leave in_ready high; a reply holds in_ready low until
//   its last word is loaded
// the pin reply (27 words) is paced by the one-word-per-step sequencer
// reset: arst_n clears mode, link phase, counters, handle, checksum and registers
// ----------------------------------------------------------------------------
// bt_module_command_handshake
// command handshake engine for a serial bluetooth module: parses length framed
// messages, answers them through a microcoded reply sequencer
// ----------------------------------------------------------------------------
module bt_module_command_handshake (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// item input
	input  wire logic                             in_valid,
	output      logic                             in_ready,
	input  wire btmch_pkg::in_word_t              in_data,
	// result output
	output      logic                             out_valid,
	input  wire logic                             out_ready,
	output      btmch_pkg::out_word_t             out_data,
	// register port
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [btmch_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [btmch_pkg::CFG_DATA_W-1:0] pwdata,
	output      logic [btmch_pkg::CFG_DATA_W-1:0] prdata,
	output      logic                             pready
);
	import btmch_pkg::*;

	// configuration registers
	logic [63:0] pin_high_q;
	logic [63:0] pin_low_q;
	logic [31:0] rx_codes_q;
	logic [7:0]  rx_connect_q;
	logic [31:0] tx_codes_q;

	// parser state
	mode_t       mode_q, mode_d;
	logic        link_q, link_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [7:0]  handle_q, handle_d;
	logic [7:0]  store_q [BODY_KEEP];
	logic [7:0]  rx_q;

	// reply datapath
	logic [15:0] sum_q;
	logic [15:0] neg_sum;
	logic [7:0]  tx_byte;
	out_word_t   out_q;
	logic        out_valid_q;

	logic                  cfg_we;
	reg_idx_t              cfg_sel;
	logic                  acc_in;
	logic                  wr_en;
	logic [BODY_IDX_W-1:0] wr_idx;
	logic [7:0]            cnt_nx;
	logic [7:0]            st_nx [3];
	logic                  start;
	logic [UPC_W-1:0]      entry;
	logic                  step_en;
	ucode_t                uword;
	seq_stat_t             stat;

	// ---------------------------------------------------------------- registers
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready;
	assign cfg_sel = reg_idx_t'(paddr[CFG_ADDR_W-1:REG_SEL_LSB]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_high_q   <= '0;
			pin_low_q    <= '0;
			rx_codes_q   <= '0;
			rx_connect_q <= '0;
			tx_codes_q   <= '0;
		end else if (cfg_we) begin
			// addresses past the last register are dropped
			unique case (cfg_sel)
				REG_PIN_HIGH:   pin_high_q   <= pwdata;
				REG_PIN_LOW:    pin_low_q    <= pwdata;
				REG_RX_CODES:   rx_codes_q   <= pwdata[31:0];
				REG_RX_CONNECT: rx_connect_q <= pwdata[7:0];
				REG_TX_CODES:   tx_codes_q   <= pwdata[31:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (cfg_sel)
			REG_PIN_HIGH:   prdata = pin_high_q;
			REG_PIN_LOW:    prdata = pin_low_q;
			REG_RX_CODES:   prdata = {32'd0, rx_codes_q};
			REG_RX_CONNECT: prdata = {56'd0, rx_connect_q};
			REG_TX_CODES:   prdata = {32'd0, tx_codes_q};
			default:        prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- parser
	// a new word is taken only while no reply program is running
	assign in_ready = !stat.busy;
	assign acc_in   = in_valid && in_ready;

	// body bytes past BODY_KEEP are counted but not kept
	assign wr_en  = acc_in && (in_data.opcode == OPC_BYTE) && (mode_q == MODE_BODY)
		&& (cnt_q < 8'(BODY_KEEP));
	assign wr_idx = cnt_q[BODY_IDX_W-1:0];
	assign cnt_nx = cnt_q + 8'd1;

	// first three body entries as they stand after this word is written
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			st_nx[k] = (wr_en && wr_idx == BODY_IDX_W'(k)) ? in_data.rx_byte : store_q[k];
		end
	end

	always_comb begin
		mode_d   = mode_q;
		link_d   = link_q;
		len_d    = len_q;
		cnt_d    = cnt_q;
		handle_d = handle_q;
		start    = 1'b0;
		entry    = PC_FWD;
		if (acc_in) begin
			unique case (opcode_t'(in_data.opcode))
				OPC_BYTE: begin
					unique case (mode_q)
						MODE_LENGTH: begin
							// zero length is ignored
							if (in_data.rx_byte != 8'd0) begin
								len_d  = in_data.rx_byte;
								cnt_d  = 8'd0;
								mode_d = MODE_BODY;
							end
						end
						MODE_BODY: begin
							cnt_d = cnt_nx;
							if (cnt_nx >= len_q) begin
								// body complete: dispatch on type, first match wins
								mode_d = MODE_LENGTH;
								priority if (st_nx[0] == rx_codes_q[7:0]) begin
									start = 1'b1;
									entry = PC_RESET_IND;
								end else if (st_nx[0] == rx_codes_q[15:8]) begin
									if (st_nx[1] != 8'd0) begin
										handle_d = st_nx[2];
									end
								end else if (st_nx[0] == rx_codes_q[23:16]) begin
									start = 1'b1;
									entry = PC_PIN_REQ;
								end else if (st_nx[0] == rx_codes_q[31:24]) begin
									start = 1'b1;
									entry = PC_CONN_REQ;
								end else if (st_nx[0] == rx_connect_q && st_nx[1] != 8'd0) begin
									// connected: hold until the next link event or start word
									start  = 1'b1;
									entry  = PC_CONN_RES;
									mode_d = MODE_HOLD;
								end else begin
									// unknown type or failed connect: no reply
								end
							end
						end
						MODE_BYPASS: begin
							start = 1'b1;
							entry = PC_FWD;
						end
						MODE_HOLD: begin
						end
					endcase
				end
				OPC_LINK: begin
					if (!link_q) begin
						link_d = 1'b1;
						mode_d = MODE_BYPASS;
					end else begin
						link_d = 1'b0;
						mode_d = MODE_LENGTH;
						start  = 1'b1;
						entry  = PC_SOFT;
					end
				end
				OPC_START: begin
					link_d = 1'b0;
					mode_d = MODE_LENGTH;
					start  = 1'b1;
					entry  = PC_HARD;
				end
				OPC_NONE: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_LENGTH;
			link_q   <= 1'b0;
			len_q    <= '0;
			cnt_q    <= '0;
			handle_q <= '0;
		end else begin
			mode_q   <= mode_d;
			link_q   <= link_d;
			len_q    <= len_d;
			cnt_q    <= cnt_d;
			handle_q <= handle_d;
		end
	end

	// body store and held byte carry no reset
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_idx] <= in_data.rx_byte;
		end
		if (acc_in) begin
			rx_q <= in_data.rx_byte;
		end
	end

	// ---------------------------------------------------------------- sequencer
	// a step fires when the output register is free or being emptied
	assign step_en = !out_valid_q || out_ready;

	btmch_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.entry   (entry),
		.step_en (step_en),
		.uword   (uword),
		.stat    (stat)
	);

	// ---------------------------------------------------------------- reply datapath
	// checksum is the two's complement of the running body sum
	assign neg_sum = 16'd0 - sum_q;

	always_comb begin
		unique case (uword.src)
			SRC_RX:     tx_byte = rx_q;
			SRC_IMM:    tx_byte = uword.imm;
			SRC_TXCODE: tx_byte = tx_codes_q[{uword.imm[1:0], 3'b000} +: 8];
			SRC_STORE:  tx_byte = store_q[BODY_IDX_W'(stat.idx) + BODY_IDX_W'(1)];
			SRC_PIN:    tx_byte = pin_byte(pin_high_q, pin_low_q, stat.idx);
			SRC_HANDLE: tx_byte = handle_q;
			SRC_SUMHI:  tx_byte = neg_sum[15:8];
			SRC_SUMLO:  tx_byte = neg_sum[7:0];
			default:    tx_byte = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (start) begin
			sum_q <= '0;
		end else if (stat.fire && uword.acc) begin
			sum_q <= sum_q + {8'd0, tx_byte};
		end
	end

	// output register: holds one word, refilled in the cycle it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.fire) begin
			out_q.kind  <= uword.kind;
			out_q.value <= tx_byte;
			out_q.last  <= uword.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

>>> hw/rtl/btmch_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btmch_checker
// port level checks on the result channel of the command handshake engine
// ----------------------------------------------------------------------------
`include "bt_module_command_handshake_macros.svh"

module btmch_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire btmch_pkg::out_word_t out_data
);
	import btmch_pkg::*;

	// a stalled word holds
	`BTMCH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result word changed")

	// strobes carry no byte
	`BTMCH_ASSERT(a_strobe_zero, out_valid && (out_data.kind == KIND_ACCEPT || out_data.kind == KIND_SOFT || out_data.kind == KIND_HARD) |-> out_data.value == 8'd0, "strobe word with nonzero value")

	// forwarded bytes and reset strobes end their item
	`BTMCH_ASSERT(a_single_last, out_valid && (out_data.kind == KIND_FWD || out_data.kind == KIND_SOFT || out_data.kind == KIND_HARD) |-> out_data.last, "single word result without last")

	// the accept strobe is always followed by the open stream reply
	`BTMCH_ASSERT(a_accept_not_last, out_valid && out_data.kind == KIND_ACCEPT |-> !out_data.last, "accept strobe marked last")

	// the open stream reply starts right after the strobe with its length byte
	`BTMCH_ASSERT_NEXT(a_accept_then_len, out_valid && out_ready && out_data.kind == KIND_ACCEPT, out_valid && out_data.kind == KIND_TX && out_data.value == LEN_TWO_BYTE, "open stream length missing after accept")

endmodule

bind bt_module_command_handshake btmch_checker u_btmch_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire

>>> tb/sv/bt_module_command_handshake_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bt_module_command_handshake_tb
// feeds module bytes, link events and start words into the command handshake
// engine under several register settings and random idling on both sides,
// predicts every reply word and checks the output stream word by word
// ----------------------------------------------------------------------------
module bt_module_command_handshake_tb;
	import btmch_pkg::*;

	localparam int DRAIN_WAIT  = 40;      // longest reply is the pin reply
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 10;
	localparam int PHASE_WORDS = 22;      // counted words per random phase

	// dut ports
	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_word_t              in_data  = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_word_t             out_data;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr    = '0;
	logic [CFG_DATA_W-1:0] pwdata   = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	// shadow registers of the register file
	logic [63:0] pin_hi_q   = '0;
	logic [63:0] pin_lo_q   = '0;
	logic [31:0] rx_codes_q = '0;
	logic [31:0] tx_codes_q = '0;
	logic [7:0]  rx_conn_q  = '0;

	// shadow of the parser and link state
	mode_t       mode_q     = MODE_LENGTH;
	logic        linked_q   = 1'b0;
	logic [7:0]  body_len_q = '0;
	logic [7:0]  body_cnt_q = '0;
	logic [7:0]  handle_q   = '0;
	logic [7:0]  body_q [BODY_KEEP];
	logic [7:0]  reply_body [24];

	// reply words still owed by the block, oldest first
	out_word_t   reply_q [$];

	int send_gap_pct   = 0;
	int recv_stall_pct = 0;
	int mismatches     = 0;
	int cycle_cnt      = 0;

	bt_module_command_handshake u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop if the block hangs
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic void note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("mismatch: %s", msg);
		end
	endfunction

	// ------------------------------------------------------------------------
	// reply prediction
	// ------------------------------------------------------------------------
	function automatic void push_word(input kind_t k, input logic [7:0] v);
		out_word_t w;
		w.kind  = k;
		w.value = v;
		w.last  = 1'b0;
		reply_q.push_back(w);
	endfunction

	// length byte, body, then the negated 16-bit byte sum, high byte first
	function automatic void push_frame(input int len);
		logic [15:0] sum;
		sum = '0;
		for (int i = 0; i < len; i++) begin
			sum += 16'(reply_body[i]);
		end
		sum = -sum;
		push_word(KIND_TX, 8'(len + 2));
		for (int i = 0; i < len; i++) begin
			push_word(KIND_TX, reply_body[i]);
		end
		push_word(KIND_TX, sum[15:8]);
		push_word(KIND_TX, sum[7:0]);
	endfunction

	// pin byte i, byte 0 in the top bits of the high register
	function automatic logic [7:0] pin_at(input int i);
		if (i >= PIN_BYTES) begin
			return 8'd0;
		end
		return (i < 8) ? pin_hi_q[63 - 8*i -: 8] : pin_lo_q[127 - 8*i -: 8];
	endfunction

	// complete message: dispatch on the first body byte, first match wins
	function automatic void handle_message();
		logic [7:0] msg_type;
		msg_type = body_q[0];
		mode_q   = MODE_LENGTH;
		if (msg_type == rx_codes_q[7:0]) begin
			// reset indication: ask for an open port
			reply_body[0] = tx_codes_q[7:0];
			push_frame(1);
		end else if (msg_type == rx_codes_q[15:8]) begin
			// port open result: keep the handle only on success
			if (body_q[1] != 8'd0) begin
				handle_q = body_q[2];
			end
		end else if (msg_type == rx_codes_q[23:16]) begin
			// pin request: echo the address, then the 16 pin bytes
			reply_body[0] = tx_codes_q[15:8];
			for (int i = 1; i < 8; i++) begin
				reply_body[i] = body_q[i];
			end
			for (int i = 0; i < 16; i++) begin
				reply_body[8 + i] = pin_at(i);
			end
			push_frame(24);
		end else if (msg_type == rx_codes_q[31:24]) begin
			reply_body[0] = tx_codes_q[23:16];
			reply_body[1] = 8'd1;
			push_frame(2);
		end else if (msg_type == rx_conn_q && body_q[1] != 8'd0) begin
			// connected: strobe accept, open the stream, hold until a link event or start word
			push_word(KIND_ACCEPT, 8'd0);
			reply_body[0] = tx_codes_q[31:24];
			reply_body[1] = handle_q;
			push_frame(2);
			mode_q = MODE_HOLD;
		end
	endfunction

	function automatic void predict_word(input in_word_t w);
		int first;
		first = reply_q.size();
		case (opcode_t'(w.opcode))
			OPC_BYTE: begin
				case (mode_q)
					MODE_LENGTH: begin
						// a zero length is dropped
						if (w.rx_byte != 8'd0) begin
							body_len_q = w.rx_byte;
							body_cnt_q = '0;
							mode_q     = MODE_BODY;
						end
					end
					MODE_BODY: begin
						// bytes past the store are counted only
						if (body_cnt_q < BODY_KEEP) begin
							body_q[body_cnt_q] = w.rx_byte;
						end
						body_cnt_q++;
						if (body_cnt_q >= body_len_q) begin
							handle_message();
						end
					end
					MODE_BYPASS: push_word(KIND_FWD, w.rx_byte);
					default: ;
				endcase
			end
			OPC_LINK: begin
				if (!linked_q) begin
					linked_q = 1'b1;
					mode_q   = MODE_BYPASS;
				end else begin
					linked_q = 1'b0;
					mode_q   = MODE_LENGTH;
					push_word(KIND_SOFT, 8'd0);
				end
			end
			OPC_START: begin
				linked_q = 1'b0;
				mode_q   = MODE_LENGTH;
				push_word(KIND_HARD, 8'd0);
			end
			default: ;
		endcase
		if (reply_q.size() > first) begin
			reply_q[reply_q.size() - 1].last = 1'b1;
		end
	endfunction

	// ------------------------------------------------------------------------
	// reply checker and receiver stalls
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : check_replies
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (reply_q.size() == 0) begin
				note_mismatch($sformatf("unexpected word kind %0d value %h last %b",
					out_data.kind, out_data.value, out_data.last));
			end else begin
				want = reply_q.pop_front();
				if (out_data.kind !== want.kind || out_data.value !== want.value ||
					out_data.last !== want.last) begin
					note_mismatch($sformatf(
						"expected kind %0d value %h last %b, got kind %0d value %h last %b",
						want.kind, want.value, want.last,
						out_data.kind, out_data.value, out_data.last));
				end
			end
		end
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// ------------------------------------------------------------------------
	// register port
	// ------------------------------------------------------------------------
	// write one register, then read it straight back
	task automatic reg_write(input reg_idx_t idx, input logic [63:0] val);
		logic [63:0] want;
		case (idx)
			REG_PIN_HIGH: begin
				pin_hi_q = val;
				want     = val;
			end
			REG_PIN_LOW: begin
				pin_lo_q = val;
				want     = val;
			end
			REG_RX_CODES: begin
				rx_codes_q = val[31:0];
				want       = {32'd0, val[31:0]};
			end
			REG_RX_CONNECT: begin
				rx_conn_q = val[7:0];
				want      = {56'd0, val[7:0]};
			end
			default: begin
				tx_codes_q = val[31:0];
				want       = {32'd0, val[31:0]};
			end
		endcase
		// setup then access of the write
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_ADDR_W'(int'(idx) << REG_SEL_LSB);
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// read setup, same address
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) begin
			note_mismatch($sformatf("register %0d: expected %h, read %h", idx, want, prdata));
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_config(input logic [63:0] pin_hi, input logic [63:0] pin_lo,
		input logic [31:0] rx_codes, input logic [7:0] rx_conn, input logic [31:0] tx_codes);
		reg_write(REG_PIN_HIGH, pin_hi);
		reg_write(REG_PIN_LOW, pin_lo);
		// upper bits set on purpose, the narrow registers must drop them
		reg_write(REG_RX_CODES, {32'hdead_beef, rx_codes});
		reg_write(REG_RX_CONNECT, {56'h00ff_00ff_00ff_00, rx_conn});
		reg_write(REG_TX_CODES, {32'hffff_ffff, tx_codes});
	endtask

	// ------------------------------------------------------------------------
	// word sender
	// ------------------------------------------------------------------------
	// valid stays high after acceptance unless a gap or a drain follows,
	// so back-to-back words never toggle it within one step
	task automatic send_word(input opcode_t op, input logic [7:0] b);
		in_word_t w;
		w.opcode  = op;
		w.rx_byte = b;
		if ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		predict_word(w);
	endtask

	// sender pauses until every owed reply word is out and the block settles
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (reply_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// length framed message; now and then cut short and left or interrupted
	task automatic send_message(input logic [7:0] msg_type, input int len, output int sent);
		logic [7:0] b;
		int cut;
		cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, len - 1) : len;
		send_word(OPC_BYTE, 8'(len));
		sent = 1;
		for (int i = 0; i < cut; i++) begin
			if (i == 0) begin
				b = msg_type;
			end else if (i == 1) begin
				// status byte: success or failure for results
				b = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
			end else begin
				b = 8'($urandom);
			end
			send_word(OPC_BYTE, b);
			sent++;
		end
		if (cut < len) begin
			case ($urandom_range(0, 2))
				0: begin
					send_word(OPC_LINK, 8'($urandom));
					sent++;
				end
				1: begin
					send_word(OPC_START, 8'($urandom));
					sent++;
				end
				default: ;  // dropped: the next words land in the old body
			endcase
		end
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_register_access();
		apply_config({$urandom, $urandom}, {$urandom, $urandom}, 32'h4433_2211, 8'h55,
			$urandom);
	endtask

	// every message type; the first message fills the whole body store
	task automatic test_message_replies();
		logic [7:0] addr_b [8] = '{8'hff, 8'h00, 8'h5a, 8'ha5, 8'h01, 8'h80, 8'h7f, 8'h3c};
		// pin request with a long body: the ninth byte is counted, not kept
		send_word(OPC_BYTE, 8'd9);
		send_word(OPC_BYTE, rx_codes_q[23:16]);
		foreach (addr_b[i]) begin
			send_word(OPC_BYTE, addr_b[i]);
		end
		// zero length is ignored
		send_word(OPC_BYTE, 8'd0);
		// reset indication
		send_word(OPC_BYTE, 8'd1);
		send_word(OPC_BYTE, rx_codes_q[7:0]);
		// successful port open, handle a5
		send_word(OPC_BYTE, 8'd3);
		send_word(OPC_BYTE, rx_codes_q[15:8]);
		send_word(OPC_BYTE, 8'h01);
		send_word(OPC_BYTE, 8'ha5);
		// connection request
		send_word(OPC_BYTE, 8'd1);
		send_word(OPC_BYTE, rx_codes_q[31:24]);
		// successful connect result: accept strobe, open stream, hold
		send_word(OPC_BYTE, 8'd2);
		send_word(OPC_BYTE, rx_conn_q);
		send_word(OPC_BYTE, 8'h80);
	endtask

	task automatic test_link_events();
		send_word(OPC_BYTE, 8'h5a);   // dropped in hold
		send_word(OPC_LINK, 8'h00);   // connect: bypass
		send_word(OPC_BYTE, 8'hff);   // forwarded
		send_word(OPC_LINK, 8'hff);   // disconnect: soft reset
	endtask

	task automatic test_start_and_unused();
		send_word(OPC_NONE, 8'hff);   // no result
		send_word(OPC_START, 8'h00);  // hard reset strobe
	endtask

	// mostly well formed messages on the configured codes, some noise
	task automatic test_random_traffic(input int gap_pct, input int stall_pct);
		int taken;
		int sent;
		int pick;
		int len;
		logic [7:0] msg_type;
		send_gap_pct   = gap_pct;
		recv_stall_pct = stall_pct;
		taken = 0;
		while (taken < PHASE_WORDS) begin
			case (mode_q)
				MODE_BYPASS: begin
					if ($urandom_range(0, 4) == 0) begin
						send_word(OPC_LINK, 8'($urandom));
					end else begin
						send_word(OPC_BYTE, 8'($urandom));
					end
					taken++;
				end
				MODE_HOLD: begin
					// module bytes are dropped here; a link event moves on
					if ($urandom_range(0, 2) == 0) begin
						send_word(OPC_BYTE, 8'($urandom));
					end else begin
						send_word(OPC_LINK, 8'($urandom));
						taken++;
					end
				end
				default: begin
					pick = $urandom_range(0, 19);
					if (pick < 16) begin
						case ($urandom_range(0, 5))
							0: msg_type = rx_codes_q[7:0];
							1: msg_type = rx_codes_q[15:8];
							2: msg_type = rx_codes_q[23:16];
							3: msg_type = rx_codes_q[31:24];
							4: msg_type = rx_conn_q;
							default: msg_type = 8'($urandom);
						endcase
						len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14)
							: $urandom_range(1, 8);
						send_message(msg_type, len, sent);
						taken += sent;
					end else if (pick == 16) begin
						send_word(OPC_START, 8'($urandom));
						taken++;
					end else if (pick == 17) begin
						send_word(OPC_LINK, 8'($urandom));
						taken++;
					end else if (pick == 18) begin
						send_word(OPC_NONE, 8'($urandom));
					end else begin
						send_word(OPC_BYTE, 8'd0);
					end
				end
			endcase
		end
		wait_idle();
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		foreach (body_q[i]) begin
			body_q[i] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_access();

		// sender idles a little, receiver a lot
		send_gap_pct   = 19;
		recv_stall_pct = 46;
		test_message_replies();
		test_link_events();
		test_start_and_unused();
		test_random_traffic(19, 46);

		// extreme settings: shadowed codes, all-ones and all-zero pin halves
		apply_config(64'hffff_ffff_ffff_ffff, 64'h0, 32'hffff_0000, 8'hff, 32'hffff_ffff);
		test_random_traffic(46, 19);

		apply_config(64'h0, 64'hffff_ffff_ffff_ffff, 32'h7f80_fe01, 8'h00, 32'h0);
		test_random_traffic(0, 0);

		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
